FILE: design/cvp_pkg.sv
// Package for the context value predictor.
// Holds the beat payload structs, opcodes and register indexes; no dependencies.
package cvp_pkg;

  localparam int unsigned SeqWidth   = 64;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned PcWidth    = 64;
  localparam int unsigned PieceWidth = 8;
  localparam int unsigned ConfWidth  = 4;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDataWidth = 4;

  localparam logic OpPredict = 1'b0;
  localparam logic OpCommit  = 1'b1;

  localparam logic [CfgIdxWidth-1:0] RegThreshold = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegCeiling   = 1'b1;

  localparam logic [ConfWidth-1:0] ThresholdReset = 4'd7;
  localparam logic [ConfWidth-1:0] CeilingReset   = 4'd10;

  typedef struct packed {
    logic                  opcode;
    logic [SeqWidth-1:0]   seq_num;
    logic [PcWidth-1:0]    pc;
    logic [PieceWidth-1:0] piece;
    logic                  predictable;
    logic [ValueWidth-1:0] commit_value;
  } in_beat_t;

  typedef struct packed {
    logic [ValueWidth-1:0] pred_value;
    logic                  confident;
    logic                  queue_full;
    logic                  commit_matched;
  } out_beat_t;

endpackage

FILE: design/context_value_predictor_core.sv
// Context value predictor top level: two-level value predictor with pending queue.
// Depends on cvp_pkg for beat structs, opcodes and register indexes.
//
//  channel | signals                         | direction
//  in      | in_valid_i/in_ready_o/in_data_i | item beats in
//  out     | out_valid_o/out_ready_i/out_data_o | result beats out
//  cfg     | cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i | register writes
//
// After reset a clearing pass walks the tables, one entry a cycle, over all 2^INDEX_BITS
// entries; no item is taken meanwhile. An item passes through these steps from one input
// beat to the next with the output ready: accept, queue head read, first-table
// read, second-table read, execute and write back, result beat, return to idle.
// The result sits in an output register; each cycle it stalls holds the sequencer.
module context_value_predictor_core #(
  parameter int unsigned INDEX_BITS    = 12,
  parameter int unsigned PENDING_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cvp_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cvp_pkg::out_beat_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [cvp_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [cvp_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import cvp_pkg::*;

  localparam int unsigned Depth = 1 << INDEX_BITS;
  localparam int unsigned QW    = $clog2(PENDING_DEPTH);
  localparam int unsigned CW    = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned FW    = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned HW    = 4 * INDEX_BITS;

  typedef logic [INDEX_BITS-1:0] idx_t;

  // First-level entry: last value, four history words, in-flight count.
  typedef struct packed {
    logic [ValueWidth-1:0] last;
    logic [HW-1:0]         hist;
    logic [FW-1:0]         infl;
  } l1_t;
  typedef struct packed {
    logic [ValueWidth-1:0] stride;
    logic [ConfWidth-1:0]  conf;
  } l2_t;
  typedef struct packed {
    idx_t i1;
    idx_t i2;
  } pend_t;

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StRd1   = 7'b0000100,
    StRd2   = 7'b0001000,
    StExec  = 7'b0010000,
    StOut   = 7'b0100000,
    StQRd   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Tables as synchronous memories.
  l1_t   l1_mem [Depth];
  l2_t   l2_mem [Depth];
  logic [SeqWidth-1:0] pseq_mem [PENDING_DEPTH];
  pend_t pidx_mem [PENDING_DEPTH];

  l1_t   l1_rd_q;
  l2_t   l2_rd_q;
  logic [SeqWidth-1:0] pseq_rd_q;
  pend_t pidx_rd_q;

  idx_t  clr_q;
  in_beat_t item_q;
  idx_t  i1_q, i2_q;
  logic  [QW-1:0] head_q;
  logic  [CW-1:0] cnt_q;
  logic  [ConfWidth-1:0] thr_q, ceil_q;
  out_beat_t out_q;
  out_beat_t out_d;
  logic  out_v_q;

  logic  [QW-1:0] tail;
  logic  full, match;
  idx_t  i1_pred, hash, i2_rd;
  logic  [ValueWidth-1:0] stride_delta;
  l1_t   l1_wr;
  l2_t   l2_wr;
  logic  l1_we, l2_we;
  logic  [FW-1:0] infl_dec;
  logic  [ConfWidth:0] conf_inc;

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [QW:0] s;
    s    = {1'b0, head_q} + (QW+1)'(cnt_q);
    tail = (s >= (QW+1)'(PENDING_DEPTH)) ? QW'(s - (QW+1)'(PENDING_DEPTH)) : QW'(s);
  end
  assign full = (cnt_q == CW'(PENDING_DEPTH));

  assign i1_pred = idx_t'(item_q.pc[INDEX_BITS+1:2]) ^ idx_t'(item_q.piece);
  assign hash = idx_t'(l1_rd_q.hist[INDEX_BITS-1:0]
              ^ (l1_rd_q.hist[2*INDEX_BITS-1:INDEX_BITS] >> 1)
              ^ (l1_rd_q.hist[3*INDEX_BITS-1:2*INDEX_BITS] >> 2)
              ^ (l1_rd_q.hist[4*INDEX_BITS-1:3*INDEX_BITS] >> 3));
  // Predict reads the second table at the hash of the fresh first-table entry.
  assign i2_rd = (item_q.opcode == OpPredict) ? hash : i2_q;
  assign match = (cnt_q != '0) && (pseq_rd_q == item_q.seq_num);
  assign stride_delta = item_q.commit_value - l1_rd_q.last;
  assign infl_dec = (l1_rd_q.infl != '0) ? l1_rd_q.infl - FW'(1) : '0;
  assign conf_inc = {1'b0, l2_rd_q.conf} + (ConfWidth+1)'(1);

  // Write-back values for the clear sweep and the execute step.
  always_comb begin
    l1_wr = l1_rd_q;
    l2_wr = l2_rd_q;
    l1_we = 1'b0;
    l2_we = 1'b0;
    if (state_q == StClear) begin
      l1_wr = '0;
      l2_wr = '0;
      l1_we = 1'b1;
      l2_we = 1'b1;
    end else if (state_q == StExec) begin
      if (item_q.opcode == OpPredict) begin
        if (item_q.predictable && !full) begin
          l1_wr.infl = l1_rd_q.infl + FW'(1);
          l1_we = 1'b1;
        end
      end else if (match) begin
        l1_we = 1'b1;
        l2_we = 1'b1;
        l1_wr.infl = infl_dec;
        if (infl_dec == '0) begin
          l1_wr.hist = {l1_rd_q.hist[3*INDEX_BITS-1:0], l1_rd_q.last[INDEX_BITS-1:0]};
          l1_wr.last = item_q.commit_value;
        end
        if (l2_rd_q.stride == stride_delta) begin
          l2_wr.conf = (conf_inc > {1'b0, ceil_q}) ? ceil_q : conf_inc[ConfWidth-1:0];
        end else if (l2_rd_q.conf == '0) begin
          l2_wr.stride = stride_delta;
        end else begin
          l2_wr.conf = l2_rd_q.conf - ConfWidth'(1);
        end
      end
    end
  end

  // Result beat built during the execute step.
  always_comb begin
    out_d = '0;
    if (item_q.opcode == OpPredict) begin
      out_d.pred_value = l1_rd_q.last + l2_rd_q.stride;
      out_d.confident  = (l2_rd_q.conf >= thr_q);
      out_d.queue_full = item_q.predictable && full;
    end else begin
      out_d.commit_matched = match;
    end
  end

  // Memory ports: address is the clear sweep or the current entry.
  always_ff @(posedge clk_i) begin
    if (l1_we) l1_mem[(state_q == StClear) ? clr_q : i1_q] <= l1_wr;
    if (l2_we) l2_mem[(state_q == StClear) ? clr_q : i2_q] <= l2_wr;
    if (state_q == StRd1) l1_rd_q <= l1_mem[i1_q];
    if (state_q == StRd2) l2_rd_q <= l2_mem[i2_rd];
    if (state_q == StExec && item_q.opcode == OpPredict && item_q.predictable && !full) begin
      pseq_mem[tail] <= item_q.seq_num;
      pidx_mem[tail] <= '{i1: i1_q, i2: i2_q};
    end
    pseq_rd_q <= pseq_mem[head_q];
    pidx_rd_q <= pidx_mem[head_q];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_q == idx_t'(Depth - 1)) state_d = StIdle;
      StIdle:  if (in_valid_i) state_d = StQRd;
      StQRd:   state_d = StRd1;
      StRd1:   state_d = StRd2;
      StRd2:   state_d = StExec;
      StExec:  state_d = StOut;
      StOut:   if (!out_v_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) item_q <= in_data_i;
    if (state_q == StQRd) begin
      // Pick the table indexes: predict from pc and piece, commit from the oldest entry.
      i1_q <= (item_q.opcode == OpPredict) ? i1_pred : pidx_rd_q.i1;
      i2_q <= pidx_rd_q.i2;
    end
    if (state_q == StRd2 && item_q.opcode == OpPredict) i2_q <= hash;
  end

  // Sequencer, queue pointers, registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
      thr_q   <= ThresholdReset;
      ceil_q  <= CeilingReset;
      out_v_q <= 1'b0;
      out_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + idx_t'(1);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegThreshold: thr_q <= cfg_data_i;
          RegCeiling:   ceil_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == StExec) begin
        out_v_q <= 1'b1;
        out_q   <= out_d;
        if (item_q.opcode == OpPredict) begin
          if (item_q.predictable && !full) cnt_q <= cnt_q + CW'(1);
        end else if (match) begin
          head_q <= (head_q == QW'(PENDING_DEPTH - 1)) ? '0 : head_q + QW'(1);
          cnt_q  <= cnt_q - CW'(1);
        end
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for context_value_predictor_core: drives predict/commit beats,
// predicts each result with a local table model, and compares. Depends on cvp_pkg.
module tb_top;
  import cvp_pkg::*;

  localparam int unsigned IdxBits   = 12;
  localparam int unsigned TblSize   = 1 << IdxBits;
  localparam int unsigned QDepth    = 64;
  localparam int unsigned StallLimit = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_beat_t in_data;
  out_beat_t out_data;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  context_value_predictor_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Predictor state, mirroring the block's tables.
  logic [63:0] last_val [TblSize];
  logic [IdxBits-1:0] hist [TblSize][4];
  int unsigned inflight [TblSize];
  logic [63:0] stride [TblSize];
  logic [3:0] conf [TblSize];
  logic [63:0] pend_seq [QDepth];
  logic [IdxBits-1:0] pend_l1 [QDepth], pend_l2 [QDepth];
  int unsigned q_head, q_count;
  logic [3:0] threshold, ceiling;

  in_beat_t item_q [$];
  out_beat_t expected_q [$];
  logic [63:0] live_seqs [$];    // sequence numbers queued, oldest first
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned errors, beats_in, beats_out, matched, dropped, idle_cycles;
  longint unsigned seq_ctr;
  bit stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, beats_out);
    errors++;
  endtask

  // Compute the expected result of one beat and update predictor state.
  function automatic out_beat_t predict_beat(input in_beat_t b);
    out_beat_t r;
    logic [IdxBits-1:0] i1, i2;
    logic [63:0] ns;
    int unsigned t;
    r = '0;
    if (b.opcode == OpPredict) begin
      i1 = IdxBits'((b.pc >> 2) ^ 64'(b.piece));
      i2 = hist[i1][0] ^ (hist[i1][1] >> 1) ^ (hist[i1][2] >> 2) ^ (hist[i1][3] >> 3);
      r.pred_value = last_val[i1] + stride[i2];
      r.confident = conf[i2] >= threshold;
      if (b.predictable) begin
        if (q_count >= QDepth) begin
          r.queue_full = 1'b1;
        end else begin
          t = (q_head + q_count) % QDepth;
          pend_seq[t] = b.seq_num;
          pend_l1[t] = i1;
          pend_l2[t] = i2;
          q_count++;
          inflight[i1]++;
        end
      end
    end else if (q_count > 0 && pend_seq[q_head] == b.seq_num) begin
      i1 = pend_l1[q_head];
      i2 = pend_l2[q_head];
      ns = b.commit_value - last_val[i1];
      if (inflight[i1] > 0) inflight[i1]--;
      if (inflight[i1] == 0) begin
        hist[i1][3] = hist[i1][2];
        hist[i1][2] = hist[i1][1];
        hist[i1][1] = hist[i1][0];
        hist[i1][0] = last_val[i1][IdxBits-1:0];
        last_val[i1] = b.commit_value;
      end
      if (stride[i2] == ns) begin
        conf[i2] = (conf[i2] >= ceiling) ? ceiling : conf[i2] + 4'd1;
      end else if (conf[i2] == 0) begin
        stride[i2] = ns;
      end else begin
        conf[i2]--;
      end
      q_head = (q_head + 1) % QDepth;
      q_count--;
      r.commit_matched = 1'b1;
    end
    return r;
  endfunction

  // Queue a predict beat; a predictable one is also kept for a later commit.
  task automatic add_predict(input logic [63:0] pc, input logic [7:0] piece,
                             input logic pred);
    in_beat_t b;
    b = '0;
    b.opcode = OpPredict;
    b.seq_num = seq_ctr++;
    b.pc = pc;
    b.piece = piece;
    b.predictable = pred;
    b.commit_value = {$urandom, $urandom};
    item_q.push_back(b);
    if (pred && live_seqs.size() < QDepth) live_seqs.push_back(b.seq_num);
  endtask

  task automatic add_commit(input logic [63:0] seq, input logic [63:0] val);
    in_beat_t b;
    b = '0;
    b.opcode = OpCommit;
    b.seq_num = seq;
    b.commit_value = val;
    b.pc = {$urandom, $urandom};
    b.piece = $urandom;
    b.predictable = $urandom;
    item_q.push_back(b);
  endtask

  task automatic wait_drained();
    while (item_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [3:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegThreshold) threshold = val;
    else ceiling = val;
  endtask

  // One random phase: strided value streams on a few pcs with in-order commits.
  task automatic random_phase(input int n);
    logic [63:0] base, step, pcs [4];
    int k;
    for (int j = 0; j < 4; j++) pcs[j] = {$urandom, $urandom};
    base = {$urandom, $urandom};
    step = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : $urandom_range(0, 16);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 5) begin
        add_predict($urandom_range(0, 7) == 0 ? {$urandom, $urandom}
                    : pcs[$urandom_range(0, 3)], $urandom_range(0, 1) ? 8'd0 : 8'($urandom),
                    $urandom_range(0, 7) != 0);
      end else if (k < 9 && live_seqs.size() != 0) begin
        base += step;
        add_commit(live_seqs.pop_front(),
                   $urandom_range(0, 5) == 0 ? {$urandom, $urandom} : base);
      end else begin
        // Stale or bogus commit: must not match.
        add_commit({$urandom, $urandom}, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegThreshold;
    cfg_data = '0;
    threshold = ThresholdReset;
    ceiling = CeilingReset;
    send_idle_pct = 34;
    recv_idle_pct = 62;
    seq_ctr = 64'd100;
    for (int i = 0; i < TblSize; i++) begin
      last_val[i] = '0;
      stride[i] = '0;
      conf[i] = '0;
      inflight[i] = 0;
      for (int j = 0; j < 4; j++) hist[i][j] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, commit on empty queue, confidence saturation.
    add_commit(64'hFFFF_FFFF_FFFF_FFFF, 64'd5);
    add_predict(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1);
    add_predict(64'h0, 8'h00, 1'b0);
    add_commit(live_seqs.pop_front(), 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 8; i++) begin
      add_predict(64'h40, 8'h00, 1'b1);
      add_commit(live_seqs.pop_front(), 64'(i * 3));
    end
    add_predict(64'h40, 8'h00, 1'b1);
    add_commit(64'h1234, 64'd0);  // wrong sequence number
    add_commit(live_seqs.pop_front(), 64'd24);
    wait_drained();

    // Threshold zero and ceiling below current counts.
    write_reg(RegThreshold, 4'd0);
    write_reg(RegCeiling, 4'd1);
    random_phase(120);
    // Fill the pending queue past full, then drain it.
    for (int i = 0; i < QDepth + 4; i++) add_predict(64'(i * 4), 8'h00, 1'b1);
    while (live_seqs.size() != 0) add_commit(live_seqs.pop_front(), 64'd7);
    wait_drained();

    write_reg(RegThreshold, 4'd15);
    write_reg(RegCeiling, 4'd15);
    send_idle_pct = 62;
    recv_idle_pct = 34;
    random_phase(220);
    wait_drained();

    write_reg(RegThreshold, 4'd3);
    write_reg(RegCeiling, 4'd0);
    random_phase(60);
    wait_drained();
    write_reg(RegThreshold, 4'd2);
    write_reg(RegCeiling, 4'd5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(220);
    wait_drained();
    stim_done = 1'b1;
  end

  // Driver: hold the beat until accepted, advance from the pending queue.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_beat(in_data));
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= item_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk or negedge rst_n) begin
    out_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", out_data.pred_value, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.pred_value !== want.pred_value)
            report_mismatch("pred_value", out_data.pred_value,
                            want.pred_value);
          if (out_data.confident !== want.confident)
            report_mismatch("confident", 64'(out_data.confident), 64'(want.confident));
          if (out_data.queue_full !== want.queue_full)
            report_mismatch("queue_full", 64'(out_data.queue_full), 64'(want.queue_full));
          if (out_data.commit_matched !== want.commit_matched)
            report_mismatch("commit_matched", 64'(out_data.commit_matched),
                            64'(want.commit_matched));
          matched += want.commit_matched;
          dropped += want.queue_full;
        end
      end
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // Watchdog and end of run; the clearing pass after reset is well under the limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", StallLimit);
      $display("TB_ERROR");
      $finish;
    end else if (stim_done) begin
      if (expected_q.size() != 0) report_mismatch("results left over", 64'(expected_q.size()), 0);
      $display("%0d beats in, %0d results checked, %0d commits trained, %0d queue drops",
               beats_in, beats_out, matched, dropped);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
    end
  end

endmodule
